// ===== design/dcls_pkg.sv =====
`timescale 1ns / 1ps

package dcls_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_NUM_CORES    = 2;
   localparam int DEF_COUNT_BITS   = 32;
   localparam int DEF_TASK_ID_BITS = 32;

   // Fixed widths of the ports.
   localparam int TASK_BITS      = 32;
   localparam int CFG_BITS       = 32;
   localparam int LOAD_BITS      = 14;
   localparam int CSR_INDEX_BITS = 2;

   // Number of core lanes that the ports carry.
   localparam int LANES = 2;

   // Load scale: hundredths of a percent.
   localparam logic [LOAD_BITS-1:0] SCALE = 14'd10000;

   // Request opcodes.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_CORE0 = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_CORE1 = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MONITOR_ID = 2'd2;

   typedef struct packed {
      logic sample;
      logic report;
      logic step;
   } lane_ctrl_type;

   typedef struct packed {
      logic [LOAD_BITS-1:0] load;
      logic                 valid;
   } lane_result_type;

endpackage

// ===== design/dcls_lane.sv =====
`timescale 1ns / 1ps

module dcls_lane #(
   parameter int COUNT_BITS = dcls_pkg::DEF_COUNT_BITS,
   parameter int CMP_BITS   = dcls_pkg::DEF_TASK_ID_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dcls_pkg::lane_ctrl_type  ctrl,
   input  logic [CMP_BITS-1:0]      task_id,
   input  logic                     present,
   input  logic [CMP_BITS-1:0]      idle_id,
   input  logic [CMP_BITS-1:0]      monitor_id,
   output dcls_pkg::lane_result_type result
);

   localparam int LOAD_BITS = dcls_pkg::LOAD_BITS;
   localparam int PROD_BITS = COUNT_BITS + LOAD_BITS;
   localparam int SHIFT     = LOAD_BITS - 1;

   logic [COUNT_BITS-1:0] busy_ff, busy_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [PROD_BITS-1:0]  rem_ff, rem_in;
   logic [PROD_BITS-1:0]  dvs_ff, dvs_in;
   logic [LOAD_BITS-1:0]  quot_ff, quot_in;
   logic                  has_ff, has_in;
   logic                  is_busy;
   logic                  fits;

   assign is_busy = (task_id != idle_id) && (task_id != monitor_id);

   // Saturating sample counters; a report clears them after its snapshot.
   always_comb begin
      busy_in  = busy_ff;
      total_in = total_ff;
      if (ctrl.report) begin
         busy_in  = '0;
         total_in = '0;
      end else if (ctrl.sample && present) begin
         if (total_ff != '1) begin
            total_in = total_ff + COUNT_BITS'(1);
         end
         if (is_busy && (busy_ff != '1)) begin
            busy_in = busy_ff + COUNT_BITS'(1);
         end
      end
   end

   // Restoring divide, one quotient bit a step, most significant first.
   assign fits = (rem_ff >= dvs_ff);

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      has_in  = has_ff;
      if (ctrl.report) begin
         rem_in  = PROD_BITS'(busy_ff) * PROD_BITS'(dcls_pkg::SCALE);
         dvs_in  = {1'b0, total_ff, {SHIFT{1'b0}}};
         quot_in = '0;
         has_in  = (total_ff != '0);
      end else if (ctrl.step) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         quot_in = {quot_ff[LOAD_BITS-2:0], fits};
         dvs_in  = dvs_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= '0;
         total_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      has_ff  <= has_in;
   end

   assign result.load  = quot_ff;
   assign result.valid = has_ff;

endmodule

// ===== design/dcls_merge.sv =====
`timescale 1ns / 1ps

module dcls_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_en,
   input  dcls_pkg::lane_result_type lane_result [dcls_pkg::LANES],
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [13:0]               rsp_load_core0,
   output logic                      rsp_valid_core0,
   output logic [13:0]               rsp_load_core1,
   output logic                      rsp_valid_core1,
   output logic                      out_free
);

   logic                            valid_ff, valid_in;
   dcls_pkg::lane_result_type       word_ff [dcls_pkg::LANES];
   dcls_pkg::lane_result_type       word_in [dcls_pkg::LANES];

   // A lane without samples reports zero; a quotient above full scale is clamped.
   always_comb begin
      for (int c = 0; c < dcls_pkg::LANES; c++) begin
         word_in[c].valid = lane_result[c].valid;
         if (!lane_result[c].valid) begin
            word_in[c].load = '0;
         end else if (lane_result[c].load > dcls_pkg::SCALE) begin
            word_in[c].load = dcls_pkg::SCALE;
         end else begin
            word_in[c].load = lane_result[c].load;
         end
      end
   end

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = load_en || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_load_core0  = word_ff[0].load;
   assign rsp_valid_core0 = word_ff[0].valid;
   assign rsp_load_core1  = word_ff[1].load;
   assign rsp_valid_core1 = word_ff[1].valid;

endmodule

// ===== design/dual_core_load_sampler.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    opcode, task and present bit per core
// rsp_      out        rsp_valid/stall    load and valid flag per core
// csr_      in         csr_write          csr_index, csr_wdata (no read-back)
//
// A sample word leaves the input free; the next word is taken right after it.
// A report word snapshots and scales the counters, runs the restoring divide
// in each core lane (one quotient bit per cycle) and then loads the output
// register. The input is stalled during that time. Reset is synchronous and
// active high; it clears the counters, the configuration registers and the
// sequencer. A result word held by rsp_stall does not stop sample words; a
// following report waits at its last cycle until the output register is free.

module dual_core_load_sampler #(
   parameter int NUM_CORES    = dcls_pkg::DEF_NUM_CORES,
   parameter int COUNT_BITS   = dcls_pkg::DEF_COUNT_BITS,
   parameter int TASK_ID_BITS = dcls_pkg::DEF_TASK_ID_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic [31:0]                            req_task_core0,
   input  logic                                   req_present_core0,
   input  logic [31:0]                            req_task_core1,
   input  logic                                   req_present_core1,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [13:0]                            rsp_load_core0,
   output logic                                   rsp_valid_core0,
   output logic [13:0]                            rsp_load_core1,
   output logic                                   rsp_valid_core1,
   input  logic                                   csr_write,
   input  logic [dcls_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [dcls_pkg::CFG_BITS-1:0]          csr_wdata
);

   // Task identifiers are compared in their low TASK_ID_BITS bits, and the
   // ports carry at most TASK_BITS of them.
   localparam int CMP_BITS  = (TASK_ID_BITS < dcls_pkg::TASK_BITS) ?
                              TASK_ID_BITS : dcls_pkg::TASK_BITS;
   localparam int STEP_BITS = $clog2(dcls_pkg::LOAD_BITS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [CMP_BITS-1:0]      idle_ff [dcls_pkg::LANES];
   logic [CMP_BITS-1:0]      monitor_ff;
   logic                     req_take;
   logic                     out_free;
   logic                     out_load;
   dcls_pkg::lane_ctrl_type  lane_ctrl;
   logic [CMP_BITS-1:0]      task_id [dcls_pkg::LANES];
   logic                     present [dcls_pkg::LANES];
   dcls_pkg::lane_result_type lane_result [dcls_pkg::LANES];

   // Configuration registers; an index past the list writes nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff[0] <= '0;
         idle_ff[1] <= '0;
         monitor_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            dcls_pkg::CSR_IDLE_CORE0: idle_ff[0] <= csr_wdata[CMP_BITS-1:0];
            dcls_pkg::CSR_IDLE_CORE1: idle_ff[1] <= csr_wdata[CMP_BITS-1:0];
            dcls_pkg::CSR_MONITOR_ID: monitor_ff <= csr_wdata[CMP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Words are taken only while the sequencer rests; a sample word finishes
   // in its acceptance cycle, a report word starts the divide.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_load  = (state_ff == ST_OUT) && out_free;

   assign lane_ctrl.sample = req_take && (req_opcode == dcls_pkg::OP_SAMPLE);
   assign lane_ctrl.report = req_take && (req_opcode == dcls_pkg::OP_REPORT);
   assign lane_ctrl.step   = (state_ff == ST_DIV);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (lane_ctrl.report) begin
               state_in = ST_DIV;
               step_in  = STEP_BITS'(dcls_pkg::LOAD_BITS - 1);
            end
         end
         ST_DIV: begin
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign task_id[0] = req_task_core0[CMP_BITS-1:0];
   assign task_id[1] = req_task_core1[CMP_BITS-1:0];
   assign present[0] = req_present_core0;
   assign present[1] = req_present_core1;

   // One lane per core; a core beyond NUM_CORES never counts and reports
   // no samples.
   for (genvar c = 0; c < dcls_pkg::LANES; c++) begin : g_lane
      if (c < NUM_CORES) begin : g_on
         dcls_lane #(
            .COUNT_BITS (COUNT_BITS),
            .CMP_BITS   (CMP_BITS)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (lane_ctrl),
            .task_id    (task_id[c]),
            .present    (present[c]),
            .idle_id    (idle_ff[c]),
            .monitor_id (monitor_ff),
            .result     (lane_result[c])
         );
      end else begin : g_off
         assign lane_result[c] = '0;
      end
   end

   dcls_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .load_en         (out_load),
      .lane_result     (lane_result),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_load_core0  (rsp_load_core0),
      .rsp_valid_core0 (rsp_valid_core0),
      .rsp_load_core1  (rsp_load_core1),
      .rsp_valid_core1 (rsp_valid_core1),
      .out_free        (out_free)
   );

`ifndef SYNTHESIS
   a_div_moves_on: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> (state_ff == ST_DIV) || (state_ff == ST_OUT))
      else $error("divide left toward an unexpected state");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && (step_ff == '0) |=> (state_ff == ST_OUT))
      else $error("divide did not end after its last step");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result word appeared without a finished report");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid && (state_ff == ST_IDLE))
      else $error("report result was not presented");

   a_load_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_load_core0 <= dcls_pkg::SCALE) &&
                    (rsp_load_core1 <= dcls_pkg::SCALE))
      else $error("load beyond full scale");
`endif

endmodule

// ===== bench/tb_dual_core_load_sampler.sv =====
`timescale 1ns / 1ps

module tb_dual_core_load_sampler;

   // One result word: a load and a valid flag for each core lane.
   typedef dcls_pkg::lane_result_type [dcls_pkg::LANES-1:0] report_word_type;

   // The port carries two index bits, so one index is left over. Writes to it
   // must not disturb any register.
   localparam logic [dcls_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   // Task identifiers used by the directed part.
   localparam logic [dcls_pkg::TASK_BITS-1:0] ID_IDLE0   = 32'd5;
   localparam logic [dcls_pkg::TASK_BITS-1:0] ID_IDLE1   = 32'd7;
   localparam logic [dcls_pkg::TASK_BITS-1:0] ID_MONITOR = 32'd9;

   // Time for any word that is still in flight once the last expected result
   // has been seen.
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 300000;

   // Keeps its own copy of the registers and of the busy and total counters,
   // and predicts the load report that each report word must produce.
   class load_scoreboard;
      bit [dcls_pkg::DEF_COUNT_BITS-1:0] busy_count [dcls_pkg::LANES];
      bit [dcls_pkg::DEF_COUNT_BITS-1:0] total_count [dcls_pkg::LANES];
      bit [dcls_pkg::CFG_BITS-1:0]       idle_id [dcls_pkg::LANES];
      bit [dcls_pkg::CFG_BITS-1:0]       monitor_id;
      report_word_type                   load_reports_due [$];
      int                                mismatches;
      int                                results_checked;

      function new();
         for (int c = 0; c < dcls_pkg::LANES; c++) begin
            busy_count[c]  = '0;
            total_count[c] = '0;
            idle_id[c]     = '0;
         end
         monitor_id      = '0;
         mismatches      = 0;
         results_checked = 0;
      endfunction

      function void set_register(logic [dcls_pkg::CSR_INDEX_BITS-1:0] index,
                                 logic [dcls_pkg::CFG_BITS-1:0] data);
         case (index)
            dcls_pkg::CSR_IDLE_CORE0: idle_id[0] = data;
            dcls_pkg::CSR_IDLE_CORE1: idle_id[1] = data;
            dcls_pkg::CSR_MONITOR_ID: monitor_id = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return load_reports_due.size();
      endfunction

      function bit [dcls_pkg::DEF_COUNT_BITS-1:0] bump(
            bit [dcls_pkg::DEF_COUNT_BITS-1:0] value);
         return (value == '1) ? value : value + 1'b1;
      endfunction

      function void note_request(logic opcode, logic [dcls_pkg::TASK_BITS-1:0] task0,
                                 logic present0, logic [dcls_pkg::TASK_BITS-1:0] task1,
                                 logic present1);
         logic [dcls_pkg::TASK_BITS-1:0] running [dcls_pkg::LANES];
         logic                           present [dcls_pkg::LANES];
         report_word_type                word;
         bit [63:0]                      scaled;
         running[0] = task0;
         running[1] = task1;
         present[0] = present0;
         present[1] = present1;
         if (opcode == dcls_pkg::OP_SAMPLE) begin
            for (int c = 0; c < dcls_pkg::LANES; c++) begin
               if (c < dcls_pkg::DEF_NUM_CORES && present[c]) begin
                  total_count[c] = bump(total_count[c]);
                  if (running[c][dcls_pkg::DEF_TASK_ID_BITS-1:0] !=
                         idle_id[c][dcls_pkg::DEF_TASK_ID_BITS-1:0] &&
                      running[c][dcls_pkg::DEF_TASK_ID_BITS-1:0] !=
                         monitor_id[dcls_pkg::DEF_TASK_ID_BITS-1:0])
                     busy_count[c] = bump(busy_count[c]);
               end
            end
         end else begin
            // The report snapshots the counters and clears them at once.
            for (int c = 0; c < dcls_pkg::LANES; c++) begin
               word[c].load  = '0;
               word[c].valid = 1'b0;
               if (c < dcls_pkg::DEF_NUM_CORES && total_count[c] != 0) begin
                  scaled = (64'(busy_count[c]) * 64'd10000) / 64'(total_count[c]);
                  if (scaled > 64'd10000)
                     scaled = 64'd10000;
                  word[c].load  = scaled[dcls_pkg::LOAD_BITS-1:0];
                  word[c].valid = 1'b1;
               end
               busy_count[c]  = '0;
               total_count[c] = '0;
            end
            load_reports_due.push_back(word);
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_response(report_word_type got);
         report_word_type want;
         if (load_reports_due.size() == 0) begin
            report($sformatf("result word %h arrived with no report pending", got));
            return;
         end
         want = load_reports_due.pop_front();
         results_checked++;
         for (int c = 0; c < dcls_pkg::LANES; c++) begin
            if (got[c].load !== want[c].load)
               report($sformatf("report %0d core %0d load %0d, predicted %0d",
                                results_checked, c, got[c].load, want[c].load));
            if (got[c].valid !== want[c].valid)
               report($sformatf("report %0d core %0d valid %b, predicted %b",
                                results_checked, c, got[c].valid, want[c].valid));
         end
      endtask
   endclass

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_opcode;
   logic [dcls_pkg::TASK_BITS-1:0]      req_task_core0;
   logic                                req_present_core0;
   logic [dcls_pkg::TASK_BITS-1:0]      req_task_core1;
   logic                                req_present_core1;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [dcls_pkg::LOAD_BITS-1:0]      rsp_load_core0;
   logic                                rsp_valid_core0;
   logic [dcls_pkg::LOAD_BITS-1:0]      rsp_load_core1;
   logic                                rsp_valid_core1;
   logic                                csr_write;
   logic [dcls_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [dcls_pkg::CFG_BITS-1:0]       csr_wdata;

   load_scoreboard sb = new();

   // Shared controls for the two sides. When quiet is set neither side idles.
   bit quiet           = 1'b0;
   int req_gap_pct     = 0;
   int rsp_hold_cycles = 0;
   int words_sent      = 0;
   int reports_sent    = 0;
   int settings_used   = 0;
   int cycle_count     = 0;

   always #1 clock = ~clock;

   dual_core_load_sampler DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_task_core0    (req_task_core0),
      .req_present_core0 (req_present_core0),
      .req_task_core1    (req_task_core1),
      .req_present_core1 (req_present_core1),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_load_core0    (rsp_load_core0),
      .rsp_valid_core0   (rsp_valid_core0),
      .rsp_load_core1    (rsp_load_core1),
      .rsp_valid_core1   (rsp_valid_core1),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 10;
         default: return 35;
      endcase
   endfunction

   // Picks a task for one core. A high bias favors tasks that count as busy,
   // a low one favors the idle and monitor tasks, so loads spread over the range.
   function automatic logic [dcls_pkg::TASK_BITS-1:0] pick_task(int core, int bias);
      if ($urandom_range(0, 7) < bias) begin
         case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return sb.idle_id[1 - core];
            default: return $urandom();
         endcase
      end
      return ($urandom_range(0, 1) == 0) ? sb.idle_id[core] : sb.monitor_id;
   endfunction

   // Offers one word on the input channel and returns once it is accepted.
   // Inputs change on the falling edge; acceptance is judged at the rising edge,
   // where the stall seen is the value from before the edge.
   task automatic send_word(logic opcode, logic [dcls_pkg::TASK_BITS-1:0] task0,
                            logic present0, logic [dcls_pkg::TASK_BITS-1:0] task1,
                            logic present1);
      int gap;
      gap = 0;
      if (words_sent % 32 == 0)
         req_gap_pct = pick_idle_pct();
      if (!quiet && $urandom_range(0, 99) < req_gap_pct)
         gap = $urandom_range(1, 15);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_opcode        <= opcode;
      req_task_core0    <= task0;
      req_present_core0 <= present0;
      req_task_core1    <= task1;
      req_present_core1 <= present1;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_request(opcode, task0, present0, task1, present1);
      words_sent++;
      if (opcode == dcls_pkg::OP_REPORT)
         reports_sent++;
   endtask

   task automatic send_report();
      send_word(dcls_pkg::OP_REPORT, $urandom(), 1'($urandom_range(0, 1)),
                $urandom(), 1'($urandom_range(0, 1)));
   endtask

   // Writes all three registers, and the spare index last when asked, so that a
   // stray write that lands in a real register would show up in the loads.
   task automatic program_registers(logic [dcls_pkg::CFG_BITS-1:0] idle0,
                                    logic [dcls_pkg::CFG_BITS-1:0] idle1,
                                    logic [dcls_pkg::CFG_BITS-1:0] monitor,
                                    bit with_spare);
      logic [dcls_pkg::CSR_INDEX_BITS-1:0] idx [4];
      logic [dcls_pkg::CFG_BITS-1:0]       val [4];
      int                                  count;
      idx   = '{dcls_pkg::CSR_IDLE_CORE0, dcls_pkg::CSR_IDLE_CORE1,
                dcls_pkg::CSR_MONITOR_ID, CSR_SPARE};
      val   = '{idle0, idle1, monitor, $urandom()};
      count = with_spare ? 4 : 3;
      for (int i = 0; i < count; i++) begin
         @(negedge clock);
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         sb.set_register(idx[i], val[i]);
      end
      @(negedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   // The sender stops and waits for every predicted report to come back, then
   // lets a trailing sample word finish before registers may change.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random traffic: mostly runs of sample words closed by a report, with an
   // occasional long run for fine load steps and empty runs for back-to-back
   // reports. Present bits are mostly set but drop out now and then.
   task automatic run_phase(int target);
      int sent;
      int run;
      int bias0;
      int bias1;
      sent = 0;
      while (sent < target) begin
         run   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 12);
         bias0 = $urandom_range(0, 8);
         bias1 = $urandom_range(0, 8);
         repeat (run) begin
            send_word(dcls_pkg::OP_SAMPLE, pick_task(0, bias0), $urandom_range(0, 4) != 0,
                      pick_task(1, bias1), $urandom_range(0, 4) != 0);
            sent++;
         end
         send_report();
         sent++;
      end
   endtask

   // Every accepted result word is checked against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      report_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got[0].load  = rsp_load_core0;
         got[0].valid = rsp_valid_core0;
         got[1].load  = rsp_load_core1;
         got[1].valid = rsp_valid_core1;
         sb.check_response(got);
      end
   end

   // The receiver stalls in random bursts whose density is redrawn periodically.
   // A long hold-off requested by the stimulus is counted down here,
   // one cycle at a time, while the sender keeps pushing words.
   initial begin : result_receiver
      int burst;
      int stall_pct;
      int cyc;
      burst     = 0;
      stall_pct = 0;
      cyc       = 0;
      forever begin
         @(negedge clock);
         if (cyc % 64 == 0)
            stall_pct = pick_idle_pct();
         cyc++;
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            burst = $urandom_range(1, 15) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // A run that takes far longer than the slowest legal schedule is a hang.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d reports outstanding",
               cycle_count, sb.pending());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [dcls_pkg::CFG_BITS-1:0] shared_id;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = dcls_pkg::OP_SAMPLE;
      req_task_core0    = '0;
      req_present_core0 = 1'b0;
      req_task_core1    = '0;
      req_present_core1 = 1'b0;
      rsp_stall         = 1'b0;
      csr_write         = 1'b0;
      csr_index         = dcls_pkg::CSR_IDLE_CORE0;
      csr_wdata         = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with small, readable task identifiers.
      program_registers(ID_IDLE0, ID_IDLE1, ID_MONITOR, 1'b1);

      // A report before any sample says that no load is available.
      send_report();

      // Idle, monitor and foreign-idle tasks on each core, and absent cores.
      // Both cores end at two busy samples out of four.
      send_word(dcls_pkg::OP_SAMPLE, ID_IDLE0, 1'b1, 32'd123, 1'b1);
      send_word(dcls_pkg::OP_SAMPLE, ID_MONITOR, 1'b1, ID_IDLE1, 1'b1);
      send_word(dcls_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
      send_word(dcls_pkg::OP_SAMPLE, 32'h0, 1'b0, ID_MONITOR, 1'b1);
      send_word(dcls_pkg::OP_SAMPLE, ID_IDLE1, 1'b1, ID_IDLE0, 1'b1);
      send_report();

      // One busy sample in three rounds down; core 1 never present.
      send_word(dcls_pkg::OP_SAMPLE, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0);
      send_word(dcls_pkg::OP_SAMPLE, ID_IDLE0, 1'b1, 32'd1, 1'b0);
      send_word(dcls_pkg::OP_SAMPLE, ID_MONITOR, 1'b1, 32'd2, 1'b0);
      send_report();

      // Counters must have been cleared by the previous report.
      send_report();

      // Fully busy on both cores.
      send_word(dcls_pkg::OP_SAMPLE, 32'd1, 1'b1, 32'd2, 1'b1);
      send_word(dcls_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
      send_word(dcls_pkg::OP_SAMPLE, 32'h0, 1'b1, 32'h0, 1'b1);
      send_report();

      // Fully idle on both cores: load zero but valid.
      send_word(dcls_pkg::OP_SAMPLE, ID_IDLE0, 1'b1, ID_IDLE1, 1'b1);
      send_word(dcls_pkg::OP_SAMPLE, ID_MONITOR, 1'b1, ID_MONITOR, 1'b1);
      send_report();
      settle();

      // Random phases, each under its own register setting.
      program_registers('0, '0, '0, 1'b0);
      run_phase(100);
      settle();

      // The receiver holds off for a long time at the start of this phase, so
      // the output register fills and the block stalls its input.
      program_registers('1, '1, '1, 1'b1);
      rsp_hold_cycles = LONG_HOLD;
      run_phase(100);
      settle();

      program_registers($urandom(), $urandom(), $urandom(), 1'b1);
      run_phase(100);
      settle();

      // One identifier serves as both idle tasks and as the monitor task.
      shared_id = $urandom();
      program_registers(shared_id, shared_id, shared_id, 1'b0);
      run_phase(80);
      settle();

      // Closing phase at full rate on both sides.
      quiet = 1'b1;
      program_registers($urandom(), $urandom(), $urandom(), 1'b0);
      run_phase(120);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d words (%0d reports) under %0d register settings in %0d cycles.",
               words_sent, reports_sent, settings_used, cycle_count);
      $display("Checked %0d load reports; %0d field mismatches.",
               sb.results_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/dcls_pkg.sv
design/dcls_lane.sv
design/dcls_merge.sv
design/dual_core_load_sampler.sv
bench/tb_dual_core_load_sampler.sv
